// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, expr, msg)
`endif

`endif

// File: rtl/gn2d_pkg.sv
// ----------------------------------------------------------------------------
// Gradient noise package
// Register codes, cell size limits, gradient codes and the permutation ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package gn2d_pkg;

  localparam int CELL_BITS = 13;

  localparam logic [CELL_BITS-1:0] CELL_RESET = 13'd16;
  localparam logic [CELL_BITS-1:0] CELL_MIN   = 13'd1;
  localparam logic [CELL_BITS-1:0] CELL_MAX   = 13'd4096;

  localparam logic REG_CELL_SIZE  = 1'b0;
  localparam logic REG_NOISE_SEED = 1'b1;

  localparam logic [1:0] GRAD_PP = 2'd0;
  localparam logic [1:0] GRAD_NP = 2'd1;
  localparam logic [1:0] GRAD_NN = 2'd2;
  localparam logic [1:0] GRAD_PN = 2'd3;

  localparam logic [7:0] PERM [256] = '{
    8'd208, 8'd34, 8'd231, 8'd213, 8'd32, 8'd248, 8'd233, 8'd56, 8'd161, 8'd78,
    8'd24, 8'd140, 8'd71, 8'd48, 8'd140, 8'd254, 8'd245, 8'd255, 8'd247, 8'd247,
    8'd40, 8'd185, 8'd248, 8'd251, 8'd245, 8'd28, 8'd124, 8'd204, 8'd204, 8'd76,
    8'd36, 8'd1, 8'd107, 8'd28, 8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
    8'd167, 8'd204, 8'd9, 8'd92, 8'd217, 8'd54, 8'd239, 8'd174, 8'd173, 8'd102,
    8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108, 8'd167, 8'd44, 8'd43, 8'd77,
    8'd180, 8'd204, 8'd8, 8'd81, 8'd70, 8'd223, 8'd11, 8'd38, 8'd24, 8'd254,
    8'd210, 8'd210, 8'd177, 8'd32, 8'd81, 8'd195, 8'd243, 8'd125, 8'd8, 8'd169,
    8'd112, 8'd32, 8'd97, 8'd53, 8'd195, 8'd13, 8'd203, 8'd9, 8'd47, 8'd104,
    8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203, 8'd181, 8'd235, 8'd193, 8'd206,
    8'd70, 8'd180, 8'd174, 8'd0, 8'd167, 8'd181, 8'd41, 8'd164, 8'd30, 8'd116,
    8'd127, 8'd198, 8'd245, 8'd146, 8'd87, 8'd224, 8'd149, 8'd206, 8'd57, 8'd4,
    8'd192, 8'd210, 8'd65, 8'd210, 8'd129, 8'd240, 8'd178, 8'd105, 8'd228, 8'd108,
    8'd245, 8'd148, 8'd140, 8'd40, 8'd35, 8'd195, 8'd38, 8'd58, 8'd65, 8'd207,
    8'd215, 8'd253, 8'd65, 8'd85, 8'd208, 8'd76, 8'd62, 8'd3, 8'd237, 8'd55,
    8'd89, 8'd232, 8'd50, 8'd217, 8'd64, 8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
    8'd90, 8'd17, 8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187, 8'd234, 8'd177,
    8'd73, 8'd174, 8'd193, 8'd100, 8'd192, 8'd143, 8'd97, 8'd53, 8'd145, 8'd135,
    8'd19, 8'd103, 8'd13, 8'd90, 8'd135, 8'd151, 8'd199, 8'd91, 8'd239, 8'd247,
    8'd33, 8'd39, 8'd145, 8'd101, 8'd120, 8'd99, 8'd3, 8'd186, 8'd86, 8'd99,
    8'd41, 8'd237, 8'd203, 8'd111, 8'd79, 8'd220, 8'd135, 8'd158, 8'd42, 8'd30,
    8'd154, 8'd120, 8'd67, 8'd87, 8'd167, 8'd135, 8'd176, 8'd183, 8'd191, 8'd253,
    8'd115, 8'd184, 8'd21, 8'd233, 8'd58, 8'd129, 8'd233, 8'd142, 8'd39, 8'd128,
    8'd211, 8'd118, 8'd137, 8'd139, 8'd255, 8'd114, 8'd20, 8'd218, 8'd113, 8'd154,
    8'd27, 8'd127, 8'd246, 8'd250, 8'd1, 8'd8, 8'd198, 8'd250, 8'd209, 8'd92,
    8'd222, 8'd173, 8'd21, 8'd88, 8'd102, 8'd219
  };

endpackage

`default_nettype wire

// File: rtl/gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// 2D gradient noise generator
// Fully pipelined gradient noise with quintic fade, one sample per clock.
// ----------------------------------------------------------------------------
// A request is taken on any clock edge at which start is high and busy is
// low; busy never rises, so a new point may be presented every cycle.
// Each request produces exactly one result: noise_value is valid for the
// single cycle in which done is high, and the receiver cannot hold it off.
// A request passes through a bit-per-stage restoring divider that forms the
// cell offset and the cell fraction, followed by ten stages of lookup, fade
// and blending. Throughput is one result per clock.
// The configuration port writes cell_size (index 0) or noise_seed (index 1) in the
// cycle wr_en is high; the user must write it only while no request is in flight,
// unenforced by the block. Reset empties the pipeline, restores cell_size 16, seed 0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gradient_noise_2d
  import gn2d_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [COORD_BITS-1:0]       pos_x,
  input  wire logic [COORD_BITS-1:0]       pos_y,
  output logic                             done,
  output logic signed [15:0]               noise_value,
  input  wire logic                        wr_en,
  input  wire logic                        wr_index,
  input  wire logic [CELL_BITS-1:0]        wr_data
);

  localparam int F   = FRAC_BITS;
  localparam int N   = COORD_BITS + FRAC_BITS;
  localparam int LAT = N + 11;
  localparam int QW  = (FRAC_BITS >= 14) ? FRAC_BITS + 5 : 19;

  localparam logic signed [F+1:0] ONE_D  = (F+2)'(1) << F;
  localparam logic signed [F+4:0] K15    = (F+5)'(15) << F;
  localparam logic signed [F+4:0] K10    = (F+5)'(10) << F;
  localparam logic signed [QW-1:0] QMAX  = QW'(32767);
  localparam logic signed [QW-1:0] QMIN  = QW'(-32768);

  typedef struct packed {
    logic [COORD_BITS-1:0] num;
    logic [CELL_BITS-1:0]  rem;
    logic [F-1:0]          quo;
    logic [7:0]            lo;
    logic [7:0]            c0;
    logic [7:0]            c1;
  } lane_t;

  function automatic lane_t div_step(lane_t a, logic [CELL_BITS-1:0] c, logic corner);
    lane_t          r;
    logic [CELL_BITS:0] sh;
    logic           qb;
    r = a;
    sh = {a.rem, a.num[COORD_BITS-1]};
    qb = (sh >= {1'b0, c});
    r.rem = qb ? CELL_BITS'(sh - {1'b0, c}) : sh[CELL_BITS-1:0];
    r.num = {a.num[COORD_BITS-2:0], 1'b0};
    r.quo = {a.quo[F-2:0], qb};
    if (corner) begin
      r.c0 = a.lo - a.rem[7:0];
      r.c1 = a.lo - a.rem[7:0] + c[7:0];
    end
    return r;
  endfunction

  function automatic logic signed [F+1:0] grad_dot(logic [1:0] g,
                                                   logic signed [F+1:0] dx,
                                                   logic signed [F+1:0] dy);
    logic signed [F+1:0] gx;
    logic signed [F+1:0] gy;
    gx = (g == GRAD_PP || g == GRAD_PN) ? dx : -dx;
    gy = (g == GRAD_PP || g == GRAD_NP) ? dy : -dy;
    return gx + gy;
  endfunction

  logic [CELL_BITS-1:0] cell_eff;
  logic [7:0]           seed;
  logic [CELL_BITS-1:0] cell_wr;
  logic                 accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    if (wr_data == '0) begin
      cell_wr = CELL_MIN;
    end else if (wr_data > CELL_MAX) begin
      cell_wr = CELL_MAX;
    end else begin
      cell_wr = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_eff <= CELL_RESET;
      seed     <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_CELL_SIZE:  cell_eff <= cell_wr;
        REG_NOISE_SEED: seed     <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // Divider pipeline: one quotient bit per stage for x*2^F / cell and y*2^F / cell.
  lane_t      lx [N+1];
  lane_t      ly [N+1];
  logic [N:0] dv;
  logic [9:0] pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
      pv <= '0;
    end else begin
      dv <= {dv[N-1:0], accept};
      pv <= {pv[8:0], dv[N]};
    end
  end

  always_ff @(posedge clk) begin
    lx[0] <= '{num: pos_x, rem: '0, quo: '0, lo: pos_x[7:0], c0: '0, c1: '0};
    ly[0] <= '{num: pos_y, rem: '0, quo: '0, lo: pos_y[7:0], c0: '0, c1: '0};
    for (int s = 0; s < N; s++) begin
      lx[s+1] <= div_step(lx[s], cell_eff, s == COORD_BITS);
      ly[s+1] <= div_step(ly[s], cell_eff, s == COORD_BITS);
    end
  end

  // Stage 1: first hash lookup, t*t and t*(6t - 15).
  logic [F-1:0]          txn, tyn;
  logic [7:0]            hy0_idx, hy1_idx;
  logic signed [F+4:0]   kx, ky;
  logic signed [2*F+5:0] prx, pry;
  logic [2*F-1:0]        sqx, sqy;

  logic [F-1:0]          p1_tx, p1_ty, p1_t2x, p1_t2y;
  logic signed [F+4:0]   p1_px, p1_py;
  logic [7:0]            p1_h0, p1_h1, p1_cx0, p1_cx1;

  assign txn     = lx[N].quo;
  assign tyn     = ly[N].quo;
  assign hy0_idx = seed + ly[N].c0;
  assign hy1_idx = seed + ly[N].c1;
  assign kx      = $signed({4'b0, txn, 1'b0} + {3'b0, txn, 2'b0}) - K15;
  assign ky      = $signed({4'b0, tyn, 1'b0} + {3'b0, tyn, 2'b0}) - K15;
  assign prx     = $signed({1'b0, txn}) * kx;
  assign pry     = $signed({1'b0, tyn}) * ky;
  assign sqx     = txn * txn;
  assign sqy     = tyn * tyn;

  always_ff @(posedge clk) begin
    p1_tx  <= txn;
    p1_ty  <= tyn;
    p1_t2x <= sqx[2*F-1:F];
    p1_t2y <= sqy[2*F-1:F];
    p1_px  <= prx[2*F+4:F];
    p1_py  <= pry[2*F+4:F];
    p1_h0  <= PERM[hy0_idx];
    p1_h1  <= PERM[hy1_idx];
    p1_cx0 <= lx[N].c0;
    p1_cx1 <= lx[N].c1;
  end

  // Stage 2: gradient selection, fade u term and t^3.
  logic [7:0]          i00, i10, i01, i11;
  logic [2*F-1:0]      cbx, cby;
  logic [F-1:0]        p2_tx, p2_ty, p2_t3x, p2_t3y;
  logic signed [F+4:0] p2_ux, p2_uy;
  logic [1:0]          p2_g00, p2_g10, p2_g01, p2_g11;

  assign i00 = p1_h0 + p1_cx0;
  assign i10 = p1_h0 + p1_cx1;
  assign i01 = p1_h1 + p1_cx0;
  assign i11 = p1_h1 + p1_cx1;
  assign cbx = p1_t2x * p1_tx;
  assign cby = p1_t2y * p1_ty;

  always_ff @(posedge clk) begin
    p2_tx  <= p1_tx;
    p2_ty  <= p1_ty;
    p2_t3x <= cbx[2*F-1:F];
    p2_t3y <= cby[2*F-1:F];
    p2_ux  <= p1_px + K10;
    p2_uy  <= p1_py + K10;
    p2_g00 <= PERM[i00][1:0];
    p2_g10 <= PERM[i10][1:0];
    p2_g01 <= PERM[i01][1:0];
    p2_g11 <= PERM[i11][1:0];
  end

  // Stage 3: corner dot products and fade weights.
  logic signed [F+1:0]   dx0, dx1, dy0, dy1;
  logic signed [2*F+5:0] fpx, fpy;
  logic signed [F+1:0]   p3_d00, p3_d10, p3_d01, p3_d11;
  logic signed [F+2:0]   p3_fx, p3_fy;

  assign dx0 = $signed({2'b0, p2_tx});
  assign dy0 = $signed({2'b0, p2_ty});
  assign dx1 = dx0 - ONE_D;
  assign dy1 = dy0 - ONE_D;
  assign fpx = $signed({1'b0, p2_t3x}) * p2_ux;
  assign fpy = $signed({1'b0, p2_t3y}) * p2_uy;

  always_ff @(posedge clk) begin
    p3_d00 <= grad_dot(p2_g00, dx0, dy0);
    p3_d10 <= grad_dot(p2_g10, dx1, dy0);
    p3_d01 <= grad_dot(p2_g01, dx0, dy1);
    p3_d11 <= grad_dot(p2_g11, dx1, dy1);
    p3_fx  <= fpx[2*F+2:F];
    p3_fy  <= fpy[2*F+2:F];
  end

  // Stages 4 to 6: blend along x.
  logic signed [F+2:0]   p4_e0, p4_e1, p4_fx, p4_fy;
  logic signed [F+1:0]   p4_d00, p4_d01;
  logic signed [2*F+5:0] mx0, mx1;
  logic signed [F+3:0]   p5_m0, p5_m1;
  logic signed [F+1:0]   p5_d00, p5_d01;
  logic signed [F+2:0]   p5_fy, p6_fy;
  logic signed [F+3:0]   p6_l0, p6_l1;

  assign mx0 = p4_e0 * p4_fx;
  assign mx1 = p4_e1 * p4_fx;

  always_ff @(posedge clk) begin
    p4_e0  <= (F+3)'(p3_d10) - (F+3)'(p3_d00);
    p4_e1  <= (F+3)'(p3_d11) - (F+3)'(p3_d01);
    p4_fx  <= p3_fx;
    p4_fy  <= p3_fy;
    p4_d00 <= p3_d00;
    p4_d01 <= p3_d01;
    p5_m0  <= mx0[2*F+3:F];
    p5_m1  <= mx1[2*F+3:F];
    p5_d00 <= p4_d00;
    p5_d01 <= p4_d01;
    p5_fy  <= p4_fy;
    p6_l0  <= (F+4)'(p5_d00) + p5_m0;
    p6_l1  <= (F+4)'(p5_d01) + p5_m1;
    p6_fy  <= p5_fy;
  end

  // Stages 7 to 9: blend along y.
  logic signed [F+4:0]   p7_e;
  logic signed [F+3:0]   p7_l0, p8_l0;
  logic signed [F+2:0]   p7_fy;
  logic signed [2*F+7:0] my;
  logic signed [F+4:0]   p8_m;
  logic signed [F+4:0]   p9_v;

  assign my = p7_e * p7_fy;

  always_ff @(posedge clk) begin
    p7_e  <= (F+5)'(p6_l1) - (F+5)'(p6_l0);
    p7_l0 <= p6_l0;
    p7_fy <= p6_fy;
    p8_m  <= my[2*F+4:F];
    p8_l0 <= p7_l0;
    p9_v  <= (F+5)'(p8_l0) + p8_m;
  end

  // Stage 10: rescale to Q1.14 and saturate.
  logic signed [QW-1:0] q;

  if (FRAC_BITS >= 14) begin : g_down
    assign q = p9_v >>> (FRAC_BITS - 14);
  end else begin : g_up
    assign q = {p9_v, {(14 - FRAC_BITS){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (q > QMAX) begin
      noise_value <= 16'sh7fff;
    end else if (q < QMIN) begin
      noise_value <= -16'sh8000;
    end else begin
      noise_value <= q[15:0];
    end
  end

  assign done = pv[9];

  `ASSERT_PROP(a_latency, clk, rst, accept |-> ##LAT done, "request produced no result")
  `ASSERT_PROP(a_no_extra, clk, rst, done |-> $past(accept, LAT), "result without request")
  `ASSERT_NEVER(a_cell_range, clk, rst, (cell_eff == '0) || (cell_eff > CELL_MAX),
                "cell size out of range")

endmodule

`default_nettype wire
